### hw/rtl/lpmt_pkg.sv
package lpmt_pkg;

  localparam int KEY_W  = 32;
  localparam int PLEN_W = 6;
  localparam int HOP_W  = 32;
  localparam int PORT_W = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic STAT_OK         = 1'b0;
  localparam logic STAT_POOL_EMPTY = 1'b1;

  // Route stored at a trie node: valid flag, next hop, output port.
  typedef struct packed {
    logic              valid;
    logic [HOP_W-1:0]  hop;
    logic [PORT_W-1:0] port;
  } route_t;

  // Controls for the key shift register.
  typedef struct packed {
    logic load;
    logic shift;
    logic count;
  } ksr_ctrl_t;

endpackage

### hw/rtl/lpmt_if.sv
interface lpmt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [lpmt_pkg::KEY_W-1:0]   key;
  logic [lpmt_pkg::PLEN_W-1:0]  prefix_len;
  logic [lpmt_pkg::HOP_W-1:0]   hop_in;
  logic [lpmt_pkg::PORT_W-1:0]  port_in;

  modport source (output valid, action, key, prefix_len, hop_in, port_in, input ready);
  modport sink   (input valid, action, key, prefix_len, hop_in, port_in, output ready);
endinterface

interface lpmt_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [lpmt_pkg::HOP_W-1:0]   hop_out;
  logic [lpmt_pkg::PORT_W-1:0]  port_out;
  logic                         status;

  modport source (output valid, found, hop_out, port_out, status, input ready);
  modport sink   (input valid, found, hop_out, port_out, status, output ready);
endinterface

### hw/rtl/lpmt_ram.sv
module lpmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/lpmt_keysr.sv
module lpmt_keysr #(
  parameter int KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpmt_pkg::ksr_ctrl_t               ctrl,
  input  logic [lpmt_pkg::KEY_W-1:0]        key_in,
  output logic                              key_bit,
  output logic [$clog2(KEY_BITS+1)-1:0]     level
);

  localparam int LVL_W = $clog2(KEY_BITS + 1);

  logic [KEY_BITS-1:0] key_r;
  logic [LVL_W-1:0]    level_r;

  // The key leaves one bit per trie level, top bit first.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= key_in[KEY_BITS-1:0];
    end else if (ctrl.shift) begin
      key_r <= {key_r[KEY_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (ctrl.load) begin
      level_r <= '0;
    end else if (ctrl.count) begin
      level_r <= level_r + LVL_W'(1);
    end
  end

  assign key_bit = key_r[KEY_BITS-1];
  assign level   = level_r;

endmodule

### hw/rtl/lpm_binary_trie_core.sv
// Channel   Direction  Transaction contents
// in_ch     sink       action, key, prefix_len, hop_in, port_in
// out_ch    source     found, hop_out, port_out, status
//
// A lookup makes D node visits from acceptance to result, where D is at most KEY_BITS + 1, the
// root included; each visit below the root is one node memory read. An insert walks the
// existing path the same way, then makes one decision and, when it adds nodes, patches the
// parent link and writes each new node in turn, each with its final links and route.
// Reset (synchronous, active low) empties the root and frees the whole node pool at once;
// the node memories need no clearing pass because every node is written when it is taken.
// A new transaction is accepted only when the engine is idle; a finished result waits in the
// output register, so the next transaction can be accepted while out_ch is stalled.
module lpm_binary_trie_core #(
  parameter int NODE_COUNT = 4096,
  parameter int KEY_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lpmt_in_if.sink    in_ch,
  lpmt_out_if.source out_ch
);

  // Link codes: 0 means no child, k means pool node k-1.
  localparam int LW    = $clog2(NODE_COUNT + 1);
  localparam int AW    = $clog2(NODE_COUNT);
  localparam int LVL_W = $clog2(KEY_BITS + 1);
  localparam int RW    = $bits(lpmt_pkg::route_t);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PATCH  = 3'd3;
  localparam logic [2:0] S_CREATE = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic                  act_r;
  logic [LVL_W-1:0]      limit_r;
  logic [lpmt_pkg::HOP_W-1:0]  hop_r;
  logic [lpmt_pkg::PORT_W-1:0] port_r;
  logic [LW-1:0]         cur_r;
  logic [2*LW-1:0]       cur_links_r;
  lpmt_pkg::route_t      best_r;
  logic                  status_r;
  logic [2*LW-1:0]       root_links_r;
  lpmt_pkg::route_t      root_route_r;
  logic [LW-1:0]         nodes_used_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [lpmt_pkg::HOP_W-1:0]  out_hop_r;
  logic [lpmt_pkg::PORT_W-1:0] out_port_r;
  logic                  out_status_r;

  lpmt_pkg::ksr_ctrl_t   ksr_ctrl;
  logic                  key_bit;
  logic [LVL_W-1:0]      level;

  logic                  in_fire;
  logic                  out_free;
  logic [2*LW-1:0]       links_rd;
  lpmt_pkg::route_t      route_rd;
  logic [RW-1:0]         route_rd_raw;
  logic [2*LW-1:0]       links;
  logic [LW-1:0]         nxt;
  logic                  walk_end;
  logic [LW-1:0]         cur_m1;
  logic [LVL_W-1:0]      need;
  logic [LW:0]           pool_sum;
  logic                  pool_short;
  logic [LW-1:0]         new_link;
  logic [LW:0]           chain_sum;
  logic [LW-1:0]         chain_link;
  logic                  last_new;
  logic [2*LW-1:0]       patched;
  logic [2*LW-1:0]       chain_links;
  lpmt_pkg::route_t      new_route;
  logic [lpmt_pkg::PLEN_W-1:0] plen_clamp;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  link_we;
  logic [AW-1:0]         link_waddr;
  logic [2*LW-1:0]       link_wdata;
  logic                  route_we;
  logic [AW-1:0]         route_waddr;
  logic [RW-1:0]         route_wdata;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Key bits are consumed one per level by the shift register.
  lpmt_keysr #(.KEY_BITS(KEY_BITS)) u_keysr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ksr_ctrl),
    .key_in  (in_ch.key),
    .key_bit (key_bit),
    .level   (level)
  );

  // Child links of each pool node, as {link for bit 1, link for bit 0}.
  lpmt_ram #(.WIDTH(2 * LW), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (links_rd)
  );

  // Route held by each pool node.
  lpmt_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_route_ram (
    .clk     (clk),
    .wr_en   (route_we),
    .wr_addr (route_waddr),
    .wr_data (route_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (route_rd_raw)
  );

  assign route_rd = lpmt_pkg::route_t'(route_rd_raw);

  // The root lives in flip-flops; every other node comes from the memory read of the
  // previous cycle.
  assign links    = (cur_r == '0) ? root_links_r : links_rd;
  assign nxt      = key_bit ? links[2*LW-1:LW] : links[LW-1:0];
  assign walk_end = (level == limit_r) || (nxt == '0);
  assign cur_m1   = cur_r - LW'(1);

  // An insert fails when the nodes still missing on its path exceed the free pool.
  assign need       = limit_r - level;
  assign pool_sum   = {1'b0, nodes_used_r} + (LW+1)'(need);
  assign pool_short = pool_sum > (LW+1)'(NODE_COUNT);

  // The first new node hangs off the last existing node; each later new node hangs off
  // the one created just before it, so each new node is written once with its final links.
  assign new_link    = nodes_used_r + LW'(1);
  assign chain_sum   = {1'b0, nodes_used_r} + (LW+1)'(2);
  assign chain_link  = chain_sum[LW-1:0];
  assign last_new    = (need == LVL_W'(1));
  assign patched     = key_bit ? {new_link, cur_links_r[LW-1:0]}
                               : {cur_links_r[2*LW-1:LW], new_link};
  assign chain_links = last_new ? '0
                     : (key_bit ? {chain_link, LW'(0)} : {LW'(0), chain_link});

  assign new_route  = '{valid: 1'b1, hop: hop_r, port: port_r};
  assign plen_clamp = (in_ch.prefix_len > lpmt_pkg::PLEN_W'(KEY_BITS))
                    ? lpmt_pkg::PLEN_W'(KEY_BITS) : in_ch.prefix_len;

  always_comb begin
    state_nxt      = state_r;
    ksr_ctrl       = '{load: in_fire, shift: 1'b0, count: 1'b0};
    rd_en          = 1'b0;
    rd_addr        = nxt[AW-1:0] - AW'(1);
    link_we        = 1'b0;
    link_waddr     = cur_m1[AW-1:0];
    link_wdata     = patched;
    route_we       = 1'b0;
    route_waddr    = cur_m1[AW-1:0];
    route_wdata    = new_route;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = (act_r == lpmt_pkg::ACT_LOOKUP) ? S_FIN : S_DECIDE;
        end else begin
          rd_en          = 1'b1;
          ksr_ctrl.shift = 1'b1;
          ksr_ctrl.count = 1'b1;
        end
      end
      S_DECIDE: begin
        if (pool_short) begin
          state_nxt = S_FIN;
        end else if (need == '0) begin
          route_we  = (cur_r != '0);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PATCH;
        end
      end
      S_PATCH: begin
        link_we        = (cur_r != '0);
        ksr_ctrl.shift = 1'b1;
        state_nxt      = S_CREATE;
      end
      S_CREATE: begin
        link_we        = 1'b1;
        link_waddr     = nodes_used_r[AW-1:0];
        link_wdata     = chain_links;
        route_we       = 1'b1;
        route_waddr    = nodes_used_r[AW-1:0];
        route_wdata    = last_new ? new_route : '0;
        ksr_ctrl.shift = 1'b1;
        ksr_ctrl.count = 1'b1;
        if (last_new) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      root_links_r <= '0;
      root_route_r <= '0;
      nodes_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cur_r <= '0;
      end else if (state_r == S_WALK && !walk_end) begin
        cur_r <= nxt;
      end
      if (state_r == S_DECIDE && !pool_short && need == '0 && cur_r == '0) begin
        root_route_r <= new_route;
      end
      if (state_r == S_PATCH && cur_r == '0) begin
        root_links_r <= patched;
      end
      if (state_r == S_CREATE) begin
        nodes_used_r <= nodes_used_r + LW'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r    <= in_ch.action;
      limit_r  <= (in_ch.action == lpmt_pkg::ACT_LOOKUP) ? LVL_W'(KEY_BITS)
                                                        : LVL_W'(plen_clamp);
      hop_r    <= in_ch.hop_in;
      port_r   <= in_ch.port_in;
      best_r   <= root_route_r;
      status_r <= lpmt_pkg::STAT_OK;
    end
    if (state_r == S_WALK) begin
      // The deepest node holding a route wins; empty interior nodes leave best alone.
      if (act_r == lpmt_pkg::ACT_LOOKUP && cur_r != '0 && route_rd.valid) begin
        best_r <= route_rd;
      end
      if (walk_end) begin
        cur_links_r <= links;
      end
    end
    if (state_r == S_DECIDE && pool_short) begin
      status_r <= lpmt_pkg::STAT_POOL_EMPTY;
    end
    if (state_r == S_FIN && out_free) begin
      if (act_r == lpmt_pkg::ACT_LOOKUP) begin
        out_found_r  <= best_r.valid;
        out_hop_r    <= best_r.valid ? best_r.hop : '0;
        out_port_r   <= best_r.valid ? best_r.port : '0;
        out_status_r <= lpmt_pkg::STAT_OK;
      end else begin
        out_found_r  <= 1'b0;
        out_hop_r    <= '0;
        out_port_r   <= '0;
        out_status_r <= status_r;
      end
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.hop_out  = out_hop_r;
  assign out_ch.port_out = out_port_r;
  assign out_ch.status   = out_status_r;

  // The pool never hands out more nodes than it holds.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= LW'(NODE_COUNT))
    else $error("node pool count beyond capacity");

  // Every link followed points at a node that has already been taken.
  a_cur_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= nodes_used_r)
    else $error("walk reached a node that was never taken");

  // The walk never goes deeper than its limit.
  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> level <= limit_r)
    else $error("walk went past its depth limit");

  // Each creation cycle takes exactly one node.
  a_create_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CREATE |=> nodes_used_r == $past(nodes_used_r) + LW'(1))
    else $error("node creation did not take one node");

  // A failed insert leaves the pool untouched.
  a_fail_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && pool_short) |=> $stable(nodes_used_r))
    else $error("failed insert changed the pool");

endmodule
